[hdl/trie_insert_prefix_walk_core_defines.svh]
// ----------------------------------------------------------------------------
// trie_insert_prefix_walk_core_defines: assertion macros
// shared property forms for the trie engine checkers
// ----------------------------------------------------------------------------
`ifndef TRIE_INSERT_PREFIX_WALK_CORE_DEFINES_SVH
`define TRIE_INSERT_PREFIX_WALK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define TIPW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tipw check failed");

// next-cycle implication, sampled on clock, off during reset
`define TIPW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tipw check failed");

`endif

[hdl/tipw_pkg.sv]
// ----------------------------------------------------------------------------
// tipw_pkg: trie engine shared types
// request and response words, controller to datapath commands
// ----------------------------------------------------------------------------
package tipw_pkg;

   localparam int SYMBOL_W = 8;
   localparam int NODE_W   = 12;
   localparam int PREFIX_W = 11;
   localparam int COUNT_W  = 16;
   localparam int ID_W     = 16;

   localparam logic [SYMBOL_W-1:0] OFFSET_RESET = 8'd97;

   // req_type codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [SYMBOL_W-1:0] symbol;
      logic                last_symbol;
   } req_word_type;

   typedef struct packed {
      logic [NODE_W-1:0]   node_reached;
      logic                matched;
      logic [PREFIX_W-1:0] prefix_length;
      logic [COUNT_W-1:0]  pass_count;
      logic [ID_W-1:0]     string_id;
      logic                store_full;
      logic                bad_symbol;
      logic                last_result;
   } rsp_word_type;

   typedef struct packed {
      logic clear_root;
      logic step;
      logic finish;
   } dp_cmd_type;

endpackage

[hdl/tipw_ctrl.sv]
// ----------------------------------------------------------------------------
// tipw_ctrl: trie engine sequencer
// root clear after reset, then step / finish per word with output hold
// ----------------------------------------------------------------------------
module tipw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tipw_pkg::dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.clear_root = (state_ff == S_INIT);
      cmd.step       = (state_ff == S_IDLE) && req_valid;
      cmd.finish     = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (cmd.finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_INIT;
            end
         endcase
      end
   end

endmodule

[hdl/tipw_datapath.sv]
// ----------------------------------------------------------------------------
// tipw_datapath: trie engine storage and step logic
// child row memory, pass count memory, cursor and string bookkeeping
// ----------------------------------------------------------------------------
module tipw_datapath #(
   parameter int ALPHABET  = 26,
   parameter int MAX_NODES = 4096,
   parameter int MAX_LEN   = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tipw_pkg::dp_cmd_type                    cmd,
   input  tipw_pkg::req_word_type                  req_word,
   input  logic                                    csr_we,
   input  logic [tipw_pkg::SYMBOL_W-1:0]           csr_wdata,
   output tipw_pkg::rsp_word_type                  rsp_word
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int UW = $clog2(MAX_NODES + 1);
   localparam int SW = $clog2(ALPHABET);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int RW = ALPHABET * NW;
   localparam int CW = tipw_pkg::COUNT_W;
   localparam int DW = tipw_pkg::SYMBOL_W + 1;

   // one row per node holds all its child links
   logic [RW-1:0] row_mem [MAX_NODES];
   logic [CW-1:0] cnt_mem [MAX_NODES];

   logic [RW-1:0] row_rd_ff;
   logic [CW-1:0] cnt_rd_ff;

   logic [tipw_pkg::SYMBOL_W-1:0] offset_ff;
   logic [NW-1:0]                 cursor_ff;
   logic [NW-1:0]                 cursor_in;
   logic [LW-1:0]                 len_ff;
   logic                          still_ff;
   logic [tipw_pkg::ID_W-1:0]     strings_ff;
   logic [UW-1:0]                 nodes_used_ff;

   // per-word flags carried to the response cycle
   logic matched_ff;
   logic full_ff;
   logic bad_ff;
   logic last_ff;
   logic insert_ff;
   logic alloc_ff;

   tipw_pkg::rsp_word_type rsp_word_ff;

   logic [NW-1:0] child_arr [ALPHABET];
   logic [RW-1:0] row_upd;
   logic [DW-1:0] diff;
   logic [SW-1:0] slot;
   logic          bad_sym;
   logic          is_query;
   logic [NW-1:0] child_old;
   logic [NW-1:0] child_new;
   logic          no_child;
   logic          full_cond;
   logic          active;
   logic          step_match;
   logic          step_alloc;
   logic          step_inc;
   logic [CW-1:0] cnt_inc;

   logic          row_we;
   logic [NW-1:0] row_wa;
   logic [RW-1:0] row_wd;
   logic          cnt_we;
   logic [NW-1:0] cnt_wa;
   logic [CW-1:0] cnt_wd;

   // child row split into slots, and the row with one slot replaced
   for (genvar i = 0; i < ALPHABET; i++) begin : g_slot
      assign child_arr[i]           = row_rd_ff[i*NW +: NW];
      assign row_upd[i*NW +: NW]    = (slot == SW'(i)) ? child_new : child_arr[i];
   end

   // symbol to slot, out-of-range check
   assign diff     = {1'b0, req_word.symbol} - {1'b0, offset_ff};
   assign bad_sym  = (req_word.symbol < offset_ff) || (diff >= DW'(ALPHABET));
   assign slot     = diff[SW-1:0];
   assign is_query = (req_word.req_type == tipw_pkg::OP_QUERY);

   // step decision
   assign child_old  = child_arr[slot];
   assign no_child   = (child_old == '0);
   assign full_cond  = !is_query && no_child && (nodes_used_ff >= UW'(MAX_NODES));
   assign active     = still_ff && !bad_sym;
   assign step_match = active && (is_query ? !no_child : !full_cond);
   assign step_alloc = active && !is_query && no_child && !full_cond;
   assign step_inc   = active && !is_query && !full_cond;
   assign child_new  = step_alloc ? nodes_used_ff[NW-1:0] : child_old;
   assign cnt_inc    = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + CW'(1);

   // next cursor, also the read address that keeps read data on the cursor
   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.clear_root) begin
         cursor_in = '0;
      end else if (cmd.step) begin
         if (step_match) begin
            cursor_in = child_new;
         end
      end else if (cmd.finish && last_ff) begin
         cursor_in = '0;
      end
   end

   // memory write selection
   always_comb begin
      row_we = 1'b0;
      row_wa = cursor_ff;
      row_wd = '0;
      cnt_we = 1'b0;
      cnt_wa = cursor_ff;
      cnt_wd = '0;
      if (cmd.clear_root) begin
         row_we = 1'b1;
         row_wa = '0;
         cnt_we = 1'b1;
         cnt_wa = '0;
      end else if (cmd.step) begin
         row_we = step_alloc;
         row_wd = row_upd;
         cnt_we = step_inc;
         cnt_wd = cnt_inc;
      end else if (cmd.finish) begin
         // fresh node: empty row and zero count
         row_we = alloc_ff;
         cnt_we = alloc_ff;
      end
   end

   // child row memory with write-through to the registered read
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      if (row_we && (row_wa == cursor_in)) begin
         row_rd_ff <= row_wd;
      end else begin
         row_rd_ff <= row_mem[cursor_in];
      end
   end

   // pass count memory with write-through to the registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_we && (cnt_wa == cursor_in)) begin
         cnt_rd_ff <= cnt_wd;
      end else begin
         cnt_rd_ff <= cnt_mem[cursor_in];
      end
   end

   // walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= tipw_pkg::OFFSET_RESET;
         cursor_ff     <= '0;
         len_ff        <= '0;
         still_ff      <= 1'b1;
         strings_ff    <= '0;
         nodes_used_ff <= UW'(1);
      end else begin
         if (csr_we) begin
            offset_ff <= csr_wdata;
         end
         cursor_ff <= cursor_in;
         if (cmd.step) begin
            still_ff <= step_match;
            if (step_match && (len_ff != LW'(MAX_LEN))) begin
               len_ff <= len_ff + LW'(1);
            end
            if (step_alloc) begin
               nodes_used_ff <= nodes_used_ff + UW'(1);
            end
         end else if (cmd.finish && last_ff) begin
            len_ff   <= '0;
            still_ff <= 1'b1;
            if (insert_ff && (len_ff != '0)) begin
               strings_ff <= strings_ff + tipw_pkg::ID_W'(1);
            end
         end
      end
   end

   // per-word flags
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         matched_ff <= step_match;
         full_ff    <= still_ff && !bad_sym && full_cond;
         bad_ff     <= still_ff && bad_sym;
         last_ff    <= req_word.last_symbol;
         insert_ff  <= (req_word.req_type == tipw_pkg::OP_INSERT);
         alloc_ff   <= step_alloc;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_ff.node_reached  <= tipw_pkg::NODE_W'(cursor_ff);
         rsp_word_ff.matched       <= matched_ff;
         rsp_word_ff.prefix_length <= tipw_pkg::PREFIX_W'(len_ff);
         rsp_word_ff.pass_count    <= alloc_ff ? '0 : cnt_rd_ff;
         rsp_word_ff.string_id     <= strings_ff;
         rsp_word_ff.store_full    <= full_ff;
         rsp_word_ff.bad_symbol    <= bad_ff;
         rsp_word_ff.last_result   <= last_ff;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

[hdl/trie_insert_prefix_walk_core.sv]
// ----------------------------------------------------------------------------
// trie_insert_prefix_walk_core: character-at-a-time trie engine
// rsp_valid rises after req accept, through S_RESP and the valid register, stalled by rsp_ready; one word in flight
// each word is the step on the prefetched cursor row, then the child count read
// reset synchronous; a root clear in S_INIT follows before req_ready rises
// ----------------------------------------------------------------------------
module trie_insert_prefix_walk_core #(
   parameter int ALPHABET  = 26,
   parameter int MAX_NODES = 4096,
   parameter int MAX_LEN   = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tipw_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tipw_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_we,
   input  logic [tipw_pkg::SYMBOL_W-1:0] csr_wdata
);

   tipw_pkg::dp_cmd_type cmd;

   // sequencer
   tipw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // storage and step logic
   tipw_datapath #(
      .ALPHABET  (ALPHABET),
      .MAX_NODES (MAX_NODES),
      .MAX_LEN   (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_word)
   );

endmodule

[hdl/tipw_checker.sv]
// ----------------------------------------------------------------------------
// tipw_checker: port-level checks for the trie engine
// response hold, one word in flight, consistent result flags
// ----------------------------------------------------------------------------
`include "trie_insert_prefix_walk_core_defines.svh"

module tipw_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tipw_pkg::rsp_word_type rsp_word
);

   // stalled response stays offered
   `TIPW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // only one word in flight
   `TIPW_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // a match carries no error and a nonzero prefix
   `TIPW_ASSERT_NOW(a_match_clean, rsp_valid && rsp_word.matched, !rsp_word.store_full && !rsp_word.bad_symbol && (rsp_word.prefix_length != 11'd0))

   // store full and bad symbol never together
   `TIPW_ASSERT_NOW(a_errors_exclusive, rsp_valid && rsp_word.store_full, !rsp_word.bad_symbol)

endmodule

bind trie_insert_prefix_walk_core tipw_checker u_tipw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
